// ----- hdl/dds_pkg.sv -----
// Shared types, constants and width helpers for the decimal digit square root block.
package dds_pkg;

  localparam int RADICAND_W = 60;
  localparam int INT_W      = 30;
  localparam int FRAC_W     = 27;

  // Default digit places of the root: 10^TOP_POWER down to 10^-FRAC_DIGITS
  localparam int TOP_POWER_DEF   = 8;
  localparam int FRAC_DIGITS_DEF = 8;

  // BCD image of the radicand, sized for every supported top place
  localparam int DIGIT_W    = 4;
  localparam int BCD_DIGITS = 20;
  localparam int BCD_W      = BCD_DIGITS * DIGIT_W;
  localparam int PAIR_W     = 7;

  localparam logic [DIGIT_W-1:0] DIGIT_MAX    = 4'd9;
  localparam logic [DIGIT_W-1:0] DIGIT_ADJUST = 4'd3;
  localparam logic [DIGIT_W-1:0] DIGIT_HALF   = 4'd5;

  typedef logic [BCD_DIGITS-1:0][DIGIT_W-1:0] digits_t;

  // Upper bound on the bit length of 10^n (log2(10) rounded up to 3.3220)
  function automatic int pow10_bits(input int n);
    return (n * 33220) / 10000 + 1;
  endfunction

endpackage

// ----- hdl/dds_stream_if.sv -----
// Valid/ready channels for the radicand and the root result.
interface dds_req_if (
  input logic clk
);
  logic                           valid;
  logic                           ready;
  logic [dds_pkg::RADICAND_W-1:0] radicand;

  modport source (input clk, output valid, output radicand, input ready);
  modport sink   (input clk, input valid, input radicand, output ready);
endinterface

interface dds_res_if (
  input logic clk
);
  logic                       valid;
  logic                       ready;
  logic [dds_pkg::INT_W-1:0]  root_integer;
  logic [dds_pkg::FRAC_W-1:0] root_fraction;

  modport source (input clk, output valid, output root_integer, output root_fraction,
                  input ready);
  modport sink   (input clk, input valid, input root_integer, input root_fraction,
                  output ready);
endinterface

// ----- hdl/dds_bcd_conv.sv -----
// Bit-serial binary to BCD converter (shift and add-3), one radicand bit per cycle.
module dds_bcd_conv (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [dds_pkg::RADICAND_W-1:0] radicand,
  output logic                           out_valid,
  input  logic                           out_ready,
  output dds_pkg::digits_t               digits
);

  localparam int CNT_W = $clog2(dds_pkg::RADICAND_W);

  typedef enum logic [1:0] {
    C_IDLE,
    C_SHIFT,
    C_HOLD
  } conv_state_t;

  conv_state_t                    state;
  logic [CNT_W-1:0]               cnt;
  logic [dds_pkg::RADICAND_W-1:0] bin;
  logic [dds_pkg::BCD_W-1:0]      adj_flat;
  dds_pkg::digits_t               digits_next;

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < dds_pkg::BCD_DIGITS; i++) begin
      if (digits[i] >= dds_pkg::DIGIT_HALF) begin
        adj_flat[i*dds_pkg::DIGIT_W +: dds_pkg::DIGIT_W] = digits[i] + dds_pkg::DIGIT_ADJUST;
      end else begin
        adj_flat[i*dds_pkg::DIGIT_W +: dds_pkg::DIGIT_W] = digits[i];
      end
    end
  end

  assign digits_next = {adj_flat[dds_pkg::BCD_W-2:0], bin[dds_pkg::RADICAND_W-1]};
  assign in_ready    = (state == C_IDLE);
  assign out_valid   = (state == C_HOLD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        C_IDLE: begin
          if (in_valid) begin
            bin    <= radicand;
            digits <= '0;
            cnt    <= '0;
            state  <= C_SHIFT;
          end
        end
        C_SHIFT: begin
          digits <= digits_next;
          bin    <= {bin[dds_pkg::RADICAND_W-2:0], 1'b0};
          cnt    <= cnt + 1'b1;
          if (cnt == CNT_W'(dds_pkg::RADICAND_W - 1)) begin
            state <= C_HOLD;
          end
        end
        C_HOLD: begin
          if (out_ready) begin
            state <= C_IDLE;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/dds_root_unit.sv -----
// Decimal digit-by-digit root: one place per pass, each digit found by a 4-step bit search.
module dds_root_unit #(
  parameter int TOP_POWER   = dds_pkg::TOP_POWER_DEF,
  parameter int FRAC_DIGITS = dds_pkg::FRAC_DIGITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       bcd_valid,
  output logic                       bcd_ready,
  input  dds_pkg::digits_t           bcd_digits,
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic [dds_pkg::INT_W-1:0]  root_integer,
  output logic [dds_pkg::FRAC_W-1:0] root_fraction
);

  localparam int NPLACE  = TOP_POWER + FRAC_DIGITS + 1;
  localparam int RW      = dds_pkg::pow10_bits(NPLACE);
  localparam int REMW    = RW + 8;
  localparam int R20W    = RW + 5;
  localparam int TW      = REMW + 1;
  localparam int PLACE_W = $clog2(NPLACE);
  localparam int HI_IDX  = 2 * TOP_POWER + 1;
  localparam int LO_IDX  = 2 * TOP_POWER;
  localparam int DW      = dds_pkg::DIGIT_W;

  typedef enum logic [1:0] {
    R_IDLE,
    R_BRING,
    R_TEST,
    R_DONE
  } root_state_t;

  root_state_t                state;
  dds_pkg::digits_t           digits;
  logic [REMW-1:0]            rem;
  logic [R20W-1:0]            r20;
  logic [DW-1:0]              dig;
  logic [1:0]                 bitpos;
  logic [PLACE_W-1:0]         place;
  logic                       sat;
  logic [dds_pkg::INT_W-1:0]  int_acc;
  logic [dds_pkg::FRAC_W-1:0] frac_acc;

  logic                         sat_in;
  logic [dds_pkg::PAIR_W-1:0]   pair;
  logic [REMW-1:0]              rem_next;
  logic [R20W-1:0]              r20_next;
  logic [DW-1:0]                bval;
  logic [TW-1:0]                base;
  logic [TW-1:0]                term;
  logic [TW-1:0]                diff;
  logic                         fits;
  logic [DW-1:0]                dig_next;
  logic [DW-1:0]                d_used;
  logic [dds_pkg::INT_W-1:0]    int_next;
  logic [dds_pkg::FRAC_W-1:0]   frac_next;
  logic                         res_load;

  // A nonzero digit above the top pair means digit 10 would fit: saturate
  always_comb begin
    sat_in = 1'b0;
    for (int i = 0; i < dds_pkg::BCD_DIGITS; i++) begin
      if (i > HI_IDX) begin
        sat_in = sat_in | (bcd_digits[i] != '0);
      end
    end
  end

  // Bring in the next pair: rem*100 + pair, and fold the last digit into 20*root
  assign pair = dds_pkg::PAIR_W'({digits[HI_IDX], 3'b000})
              + dds_pkg::PAIR_W'({digits[HI_IDX], 1'b0})
              + dds_pkg::PAIR_W'(digits[LO_IDX]);
  assign rem_next = (rem << 6) + (rem << 5) + (rem << 2) + REMW'(pair);
  assign r20_next = (r20 << 3) + (r20 << 1)
                  + R20W'({dig, 4'b0000}) + R20W'({dig, 2'b00});

  // Raising the digit by b costs b*(20*root + 2*dig + b)
  assign bval  = DW'(1) << bitpos;
  assign base  = TW'(r20) + TW'({dig, 1'b0}) + TW'(bval);
  assign term  = base << bitpos;
  assign diff  = TW'(rem) - term;
  assign fits  = ~diff[TW-1];

  assign dig_next  = fits ? (dig | bval) : dig;
  assign d_used    = sat ? dds_pkg::DIGIT_MAX : dig_next;
  assign int_next  = (int_acc << 3) + (int_acc << 1) + dds_pkg::INT_W'(d_used);
  assign frac_next = (frac_acc << 3) + (frac_acc << 1) + dds_pkg::FRAC_W'(d_used);

  assign bcd_ready = (state == R_IDLE);
  assign res_load  = (state == R_DONE) && (!res_valid || res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= R_IDLE;
      res_valid <= 1'b0;
      bitpos    <= '0;
      place     <= '0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        R_IDLE: begin
          if (bcd_valid) begin
            digits   <= bcd_digits;
            rem      <= '0;
            r20      <= '0;
            dig      <= '0;
            place    <= '0;
            int_acc  <= '0;
            frac_acc <= '0;
            sat      <= sat_in;
            state    <= R_BRING;
          end
        end
        R_BRING: begin
          rem    <= rem_next;
          r20    <= r20_next;
          dig    <= '0;
          bitpos <= 2'd3;
          digits <= {digits[dds_pkg::BCD_DIGITS-3:0], 8'h00};
          state  <= R_TEST;
        end
        R_TEST: begin
          if (fits) begin
            rem <= diff[REMW-1:0];
          end
          dig    <= dig_next;
          bitpos <= bitpos - 1'b1;
          if (bitpos == 2'd0) begin
            if (place < PLACE_W'(TOP_POWER + 1)) begin
              int_acc <= int_next;
            end else begin
              frac_acc <= frac_next;
            end
            if (place == PLACE_W'(NPLACE - 1)) begin
              state <= R_DONE;
            end else begin
              place <= place + 1'b1;
              state <= R_BRING;
            end
          end
        end
        R_DONE: begin
          // Hold until the output register is free
          if (res_load) begin
            root_integer  <= int_acc;
            root_fraction <= frac_acc;
            state         <= R_IDLE;
          end
        end
        default: state <= R_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/decimal_digit_square_root.sv -----
// Decimal square root: radicand in, integer part and truncated fraction digits out.
// The radicand is first turned into BCD by a bit-serial shift-and-add-3 converter
// and then handed over to the root unit. The root unit works one decimal place at a
// time from 10^TOP_POWER down to 10^-FRAC_DIGITS: a bring step brings the next digit
// pair into the remainder, then a bit search finds the digit from its top bit down.
// The converter takes the next radicand as soon as it has handed the previous one
// over, so it can convert a new radicand while the root unit works on the last one;
// the pace is set by the root unit's single shared subtractor. The result sits in
// an output register until taken; a radicand of 10^(2*TOP_POWER+2) or more
// saturates every digit to 9.
module decimal_digit_square_root #(
  parameter int TOP_POWER   = dds_pkg::TOP_POWER_DEF,
  parameter int FRAC_DIGITS = dds_pkg::FRAC_DIGITS_DEF
) (
  input logic      clk,
  input logic      rst,
  dds_req_if.sink   request,
  dds_res_if.source result
);

  logic             bcd_valid;
  logic             bcd_ready;
  dds_pkg::digits_t bcd_digits;

  dds_bcd_conv u_conv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (request.valid),
    .in_ready  (request.ready),
    .radicand  (request.radicand),
    .out_valid (bcd_valid),
    .out_ready (bcd_ready),
    .digits    (bcd_digits)
  );

  dds_root_unit #(
    .TOP_POWER   (TOP_POWER),
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_root (
    .clk           (clk),
    .rst           (rst),
    .bcd_valid     (bcd_valid),
    .bcd_ready     (bcd_ready),
    .bcd_digits    (bcd_digits),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .root_integer  (result.root_integer),
    .root_fraction (result.root_fraction)
  );

endmodule

// ----- hdl/dds_checker.sv -----
// Port-level checks for the decimal digit square root block, bound to the top level.
module dds_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       res_valid,
  input logic                       res_ready,
  input logic [dds_pkg::INT_W-1:0]  root_integer,
  input logic [dds_pkg::FRAC_W-1:0] root_fraction
);

  logic [1:0] pending;
  logic       req_beat;
  logic       res_beat;

  assign req_beat = req_valid && req_ready;
  assign res_beat = res_valid && res_ready;

  // Count beats accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, req_beat} - {1'b0, res_beat};
    end
  end

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result valid dropped before the beat was taken");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(root_integer) && $stable(root_fraction))
    else $error("result payload changed while stalled");

  a_one_in_conv: assert property (@(posedge clk) disable iff (rst)
    req_beat |=> !req_ready)
    else $error("request ready stayed high while the converter is busy");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> pending != 2'd0)
    else $error("result shown with no radicand outstanding");

endmodule

bind decimal_digit_square_root dds_checker u_dds_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (request.valid),
  .req_ready     (request.ready),
  .res_valid     (result.valid),
  .res_ready     (result.ready),
  .root_integer  (result.root_integer),
  .root_fraction (result.root_fraction)
);
